[rtl/ihpq_pkg.sv]
// Package for the indexed max-heap priority queue.
// Holds operation and status codes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package ihpq_pkg;

   // handle space is fixed by the node_id field
   localparam int HANDLE_BITS    = 6;
   localparam int HANDLE_COUNT   = 64;
   localparam int OPCODE_BITS    = 3;
   localparam int PRIO_FIELD     = 64;
   localparam int STATUS_BITS    = 2;

   // request word layout
   localparam int REQ_OP_LSB     = 0;
   localparam int REQ_NODE_LSB   = 3;
   localparam int REQ_PRIO_LSB   = 9;
   localparam int REQ_DATA_BITS  = 80;

   // parameter defaults
   localparam int DEF_NODE_CAPACITY = 64;
   localparam int DEF_PRIORITY_BITS = 64;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT     = 3'd0,
      OP_REMOVE     = 3'd1,
      OP_CHANGE     = 3'd2,
      OP_RAW_INSERT = 3'd3,
      OP_RAW_REMOVE = 3'd4,
      OP_REBUILD    = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_PRESENT = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

endpackage

[rtl/ihpq_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data that holds between reads. No dependencies.
`timescale 1ns / 1ps

module ihpq_ram #(
   parameter int DEPTH = 64,
   parameter int ADDR_BITS = 6,
   parameter int WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/indexed_max_heap_priority_queue.sv]
// Indexed max-heap priority queue: sequencer plus three heap memories.
// Depends on ihpq_pkg and ihpq_ram.
`timescale 1ns / 1ps

// Usage
//   req_* : one word per operation (insert, remove, change priority, raw
//           insert, raw remove, rebuild) naming a node handle and priority.
//   rsp_* : exactly one word per request: top of heap, node count, status.
// Timing
//   A request is taken only when the sequencer is idle. Every step is a
//   read of a registered memory. A rejected request (full, present, absent)
//   passes decode, the top read and output before the next acceptance; a
//   raw insert passes accept, decode, place, the top read and output. A
//   float up reads parent handle, then parent priority per level moved; a
//   float down reads left handle, left priority with right handle, right
//   priority per level, then places; a remove first fetches the last entry.
//   Rebuild runs one float down for each inner slot, count/2 of them.
// Reset
//   Synchronous reset empties the heap at once (per-handle valid bits);
//   no clearing pass is needed.
// Back-pressure
//   The response sits in an output register; the next request is taken
//   while it waits. A finished result waits in the output state until
//   the register is free, holding the input off.
module indexed_max_heap_priority_queue
   import ihpq_pkg::*;
#(
   parameter int NODE_CAPACITY = DEF_NODE_CAPACITY,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   localparam int SW = $clog2(NODE_CAPACITY + 1),
   localparam int RSP_RAW = 1 + HANDLE_BITS + PRIO_FIELD + SW + STATUS_BITS,
   localparam int RSP_BITS = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // opcode[2:0], node_id[8:3], new_priority[72:9], zero pad
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // top_valid, top_node, top_priority, node_count, status, zero pad
   output logic [RSP_BITS-1:0]      rsp_tdata
);

   localparam int PB = PRIORITY_BITS;
   localparam int HB = HANDLE_BITS;
   localparam logic [SW-1:0] CAP = SW'(NODE_CAPACITY);
   localparam logic [SW-1:0] ONE = SW'(1);
   localparam int CNT_LSB = 1 + HB + PRIO_FIELD;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_LAST, S_LAST_P,
      S_UP, S_UP_H, S_UP_P,
      S_DN, S_DN_L, S_DN_P, S_DN_R,
      S_REB, S_REB_H, S_REB_P,
      S_PLACE, S_TOP, S_TOP_H, S_TOP_P, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [HB-1:0]     hd_ff, hd_in;
   logic [PB-1:0]     pr_ff, pr_in;
   logic [SW-1:0]     cnt_ff, cnt_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [HB-1:0]     fh_ff, fh_in;
   logic [PB-1:0]     fp_ff, fp_in;
   logic              moved_ff, moved_in;
   logic              either_ff, either_in;
   logic              reb_ff, reb_in;
   logic [SW-1:0]     ri_ff, ri_in;
   logic [HB-1:0]     hl_ff, hl_in;
   logic [HB-1:0]     hr_ff, hr_in;
   logic [PB-1:0]     pl_ff, pl_in;
   logic [1:0]        stat_ff, stat_in;
   logic [HB-1:0]     th_ff, th_in;
   logic [HANDLE_COUNT-1:0] valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_RAW-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic              sl_we, sl_re;
   logic [SW-1:0]     sl_wa, sl_ra;
   logic [HB-1:0]     sl_wd, sl_rd;
   logic              ps_we, ps_re;
   logic [HB-1:0]     ps_wa, ps_ra;
   logic [SW-1:0]     ps_wd, ps_rd;
   logic              pm_we, pm_re;
   logic [HB-1:0]     pm_wa, pm_ra;
   logic [PB-1:0]     pm_wd, pm_rd;

   logic [SW:0]       two_s, two_s1;
   logic              r_ok, best_l, best_r;
   logic [PB-1:0]     best_p;
   logic              out_free;

   // slot -> handle
   ihpq_ram #(.DEPTH(NODE_CAPACITY + 1), .ADDR_BITS(SW), .WIDTH(HB)) u_slot_ram (
      .clock, .wr_en(sl_we), .wr_addr(sl_wa), .wr_data(sl_wd),
      .rd_en(sl_re), .rd_addr(sl_ra), .rd_data(sl_rd)
   );

   // handle -> slot
   ihpq_ram #(.DEPTH(HANDLE_COUNT), .ADDR_BITS(HB), .WIDTH(SW)) u_pos_ram (
      .clock, .wr_en(ps_we), .wr_addr(ps_wa), .wr_data(ps_wd),
      .rd_en(ps_re), .rd_addr(ps_ra), .rd_data(ps_rd)
   );

   // handle -> priority
   ihpq_ram #(.DEPTH(HANDLE_COUNT), .ADDR_BITS(HB), .WIDTH(PB)) u_prio_ram (
      .clock, .wr_en(pm_we), .wr_addr(pm_wa), .wr_data(pm_wd),
      .rd_en(pm_re), .rd_addr(pm_ra), .rd_data(pm_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_data_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // child slots and float-down choice
   assign two_s  = {slot_ff, 1'b0};
   assign two_s1 = {slot_ff, 1'b1};
   assign r_ok   = (two_s1 <= {1'b0, cnt_ff});
   assign best_l = (pl_ff > fp_ff);
   assign best_p = best_l ? pl_ff : fp_ff;
   assign best_r = r_ok && (pm_rd > best_p);

   // sequencer
   always_comb begin
      state_in = state_ff;  op_in = op_ff;  hd_in = hd_ff;  pr_in = pr_ff;
      cnt_in = cnt_ff;  slot_in = slot_ff;  fh_in = fh_ff;  fp_in = fp_ff;
      moved_in = moved_ff;  either_in = either_ff;  reb_in = reb_ff;
      ri_in = ri_ff;  hl_in = hl_ff;  hr_in = hr_ff;  pl_in = pl_ff;
      stat_in = stat_ff;  th_in = th_ff;  valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      sl_we = 1'b0;  sl_wa = slot_ff;  sl_wd = fh_ff;
      sl_re = 1'b0;  sl_ra = slot_ff;
      ps_we = 1'b0;  ps_wa = fh_ff;    ps_wd = slot_ff;
      ps_re = 1'b0;  ps_ra = hd_ff;
      pm_we = 1'b0;  pm_wa = hd_ff;    pm_wd = pr_ff;
      pm_re = 1'b0;  pm_ra = fh_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tdata[REQ_OP_LSB +: OPCODE_BITS];
               hd_in   = req_tdata[REQ_NODE_LSB +: HB];
               pr_in   = req_tdata[REQ_PRIO_LSB +: PB];
               stat_in = ST_OK;
               reb_in  = 1'b0;
               ps_re   = 1'b1;
               ps_ra   = req_tdata[REQ_NODE_LSB +: HB];
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            fh_in = hd_ff;  fp_in = pr_ff;  moved_in = 1'b0;  either_in = 1'b0;
            state_in = S_TOP;
            case (op_ff)
               OP_INSERT, OP_RAW_INSERT: begin
                  if (valid_ff[hd_ff]) begin
                     stat_in = ST_PRESENT;
                  end else if (cnt_ff >= CAP) begin
                     stat_in = ST_FULL;
                  end else begin
                     cnt_in  = cnt_ff + ONE;
                     slot_in = cnt_ff + ONE;
                     pm_we   = 1'b1;
                     state_in = (op_ff == OP_INSERT) ? S_UP : S_PLACE;
                  end
               end
               OP_REMOVE, OP_RAW_REMOVE: begin
                  if (!valid_ff[hd_ff]) begin
                     stat_in = ST_ABSENT;
                  end else begin
                     valid_in[hd_ff] = 1'b0;
                     cnt_in  = cnt_ff - ONE;
                     slot_in = ps_rd;
                     if (ps_rd < cnt_ff) begin
                        // last slot fills the hole
                        sl_re = 1'b1;
                        sl_ra = cnt_ff;
                        state_in = S_LAST;
                     end
                  end
               end
               OP_CHANGE: begin
                  if (!valid_ff[hd_ff]) begin
                     stat_in = ST_ABSENT;
                  end else begin
                     pm_we     = 1'b1;
                     slot_in   = ps_rd;
                     either_in = 1'b1;
                     state_in  = S_UP;
                  end
               end
               OP_REBUILD: begin
                  ri_in = cnt_ff >> 1;
                  if ((cnt_ff >> 1) != '0) begin
                     reb_in = 1'b1;
                     state_in = S_REB;
                  end
               end
               default: begin
                  state_in = S_TOP;
               end
            endcase
         end

         S_LAST: begin
            fh_in = sl_rd;
            pm_re = 1'b1;
            pm_ra = sl_rd;
            state_in = S_LAST_P;
         end

         S_LAST_P: begin
            fp_in = pm_rd;
            either_in = 1'b1;
            state_in = (op_ff == OP_REMOVE) ? S_UP : S_PLACE;
         end

         // float up: parent handle, then its priority
         S_UP: begin
            if (slot_ff == ONE) begin
               state_in = (either_ff && !moved_ff) ? S_DN : S_PLACE;
            end else begin
               sl_re = 1'b1;
               sl_ra = slot_ff >> 1;
               state_in = S_UP_H;
            end
         end

         S_UP_H: begin
            hl_in = sl_rd;
            pm_re = 1'b1;
            pm_ra = sl_rd;
            state_in = S_UP_P;
         end

         S_UP_P: begin
            if (pm_rd >= fp_ff) begin
               state_in = (either_ff && !moved_ff) ? S_DN : S_PLACE;
            end else begin
               sl_we = 1'b1;  sl_wd = hl_ff;
               ps_we = 1'b1;  ps_wa = hl_ff;
               slot_in  = slot_ff >> 1;
               moved_in = 1'b1;
               state_in = S_UP;
            end
         end

         // float down: left handle, left priority with right handle, right priority
         S_DN: begin
            if (two_s > {1'b0, cnt_ff}) begin
               state_in = S_PLACE;
            end else begin
               sl_re = 1'b1;
               sl_ra = two_s[SW-1:0];
               state_in = S_DN_L;
            end
         end

         S_DN_L: begin
            hl_in = sl_rd;
            pm_re = 1'b1;
            pm_ra = sl_rd;
            sl_re = r_ok;
            sl_ra = two_s1[SW-1:0];
            state_in = S_DN_P;
         end

         S_DN_P: begin
            pl_in = pm_rd;
            hr_in = sl_rd;
            pm_re = r_ok;
            pm_ra = sl_rd;
            state_in = S_DN_R;
         end

         S_DN_R: begin
            if (best_r) begin
               sl_we = 1'b1;  sl_wd = hr_ff;
               ps_we = 1'b1;  ps_wa = hr_ff;
               slot_in  = two_s1[SW-1:0];
               state_in = S_DN;
            end else if (best_l) begin
               sl_we = 1'b1;  sl_wd = hl_ff;
               ps_we = 1'b1;  ps_wa = hl_ff;
               slot_in  = two_s[SW-1:0];
               state_in = S_DN;
            end else begin
               state_in = S_PLACE;
            end
         end

         // rebuild: load the entry of slot ri as the floater
         S_REB: begin
            sl_re = 1'b1;
            sl_ra = ri_ff;
            state_in = S_REB_H;
         end

         S_REB_H: begin
            fh_in = sl_rd;
            pm_re = 1'b1;
            pm_ra = sl_rd;
            state_in = S_REB_P;
         end

         S_REB_P: begin
            fp_in = pm_rd;
            slot_in = ri_ff;
            moved_in = 1'b0;
            either_in = 1'b0;
            state_in = S_DN;
         end

         // settle the floater in its final slot
         S_PLACE: begin
            sl_we = 1'b1;
            ps_we = 1'b1;
            valid_in[fh_ff] = 1'b1;
            if (reb_ff && ri_ff != ONE) begin
               ri_in = ri_ff - ONE;
               state_in = S_REB;
            end else begin
               state_in = S_TOP;
            end
         end

         S_TOP: begin
            sl_re = 1'b1;
            sl_ra = ONE;
            state_in = (cnt_ff == '0) ? S_OUT : S_TOP_H;
         end

         S_TOP_H: begin
            th_in = sl_rd;
            pm_re = 1'b1;
            pm_ra = sl_rd;
            state_in = S_TOP_P;
         end

         S_TOP_P: begin
            state_in = S_OUT;
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_data_in = {stat_ff, cnt_ff, {PRIO_FIELD{1'b0}}, {HB{1'b0}}, 1'b0};
               end else begin
                  rsp_data_in = {stat_ff, cnt_ff, PRIO_FIELD'(pm_rd), th_ff, 1'b1};
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         reb_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         reb_ff       <= reb_in;
      end
      op_ff <= op_in;  hd_ff <= hd_in;  pr_ff <= pr_in;
      slot_ff <= slot_in;  fh_ff <= fh_in;  fp_ff <= fp_in;
      moved_ff <= moved_in;  either_ff <= either_in;
      ri_ff <= ri_in;  hl_ff <= hl_in;  hr_ff <= hr_in;  pl_ff <= pl_in;
      stat_ff <= stat_in;  th_ff <= th_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP) else $error("heap count above capacity");

   a_top_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[0] == (rsp_data_ff[CNT_LSB +: SW] != '0)))
      else $error("top_valid disagrees with node_count");

   a_one_at_once: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while busy");

   a_place_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |=> valid_ff[$past(fh_ff)])
      else $error("placed handle not marked present");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the indexed max-heap priority queue.
// Drives operation words, predicts each response word with a behavioural
// heap, and compares field by field. Depends on ihpq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top
   import ihpq_pkg::*;
();

   localparam int CAP      = DEF_NODE_CAPACITY;
   localparam int SW       = $clog2(CAP + 1);
   localparam int RSP_RAW  = 1 + HANDLE_BITS + PRIO_FIELD + SW + STATUS_BITS;
   localparam int RSP_BITS = ((RSP_RAW + 7) / 8) * 8;
   localparam int PRIO_LSB = 1 + HANDLE_BITS;
   localparam int CNT_LSB  = PRIO_LSB + PRIO_FIELD;
   localparam int ST_LSB   = CNT_LSB + SW;
   localparam int WATCHDOG = 20000;
   localparam int N_RANDOM = 620;

   typedef struct packed {
      logic [2:0]  op;
      logic [5:0]  node;
      logic [63:0] prio;
   } heap_op_type;

   typedef struct packed {
      logic        top_valid;
      logic [5:0]  top_node;
      logic [63:0] top_prio;
      logic [6:0]  count;
      logic [1:0]  status;
   } heap_view_type;

   typedef struct {
      heap_op_type   cmd;
      logic          has_view;
      heap_view_type view;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;

   // behavioural heap state
   logic [5:0]  mdl_slot_node [1:CAP];
   logic [6:0]  mdl_node_slot [0:HANDLE_COUNT-1];
   logic [63:0] mdl_node_prio [0:HANDLE_COUNT-1];
   int          mdl_count;

   heap_view_type expected_views [$];
   int          errors = 0;
   int          words_out = 0;
   int          idle_cycles = 0;
   logic        hold_off = 1'b0;
   logic        stim_done = 1'b0;
   int          op_seen [0:7];
   int          st_seen [0:3];

   always #10 clock = ~clock;

   indexed_max_heap_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---- behavioural heap ----
   function automatic logic [63:0] prio_of(int s);
      return mdl_node_prio[mdl_slot_node[s]];
   endfunction

   function automatic void put(logic [5:0] h, int s);
      mdl_slot_node[s] = h;
      mdl_node_slot[h] = s[6:0];
   endfunction

   function automatic void swap(int a, int b);
      logic [5:0] ha;
      logic [5:0] hb;
      ha = mdl_slot_node[a];
      hb = mdl_slot_node[b];
      put(hb, a);
      put(ha, b);
   endfunction

   function automatic bit bubble_up(int s);
      bit moved;
      moved = 0;
      while (s > 1 && prio_of(s / 2) < prio_of(s)) begin
         swap(s / 2, s);
         moved = 1;
         s = s / 2;
      end
      return moved;
   endfunction

   function automatic void bubble_down(int s);
      int l;
      int best;
      forever begin
         l = 2 * s;
         if (l > mdl_count) break;
         best = s;
         if (prio_of(l) > prio_of(best)) best = l;
         if (l + 1 <= mdl_count && prio_of(l + 1) > prio_of(best)) best = l + 1;
         if (best == s) break;
         swap(best, s);
         s = best;
      end
   endfunction

   function automatic logic [1:0] heap_add(logic [5:0] h, logic [63:0] p, bit sort);
      if (mdl_node_slot[h] != 0) return ST_PRESENT;
      if (mdl_count >= CAP) return ST_FULL;
      mdl_count++;
      put(h, mdl_count);
      mdl_node_prio[h] = p;
      if (sort) void'(bubble_up(mdl_count));
      return ST_OK;
   endfunction

   function automatic logic [1:0] heap_drop(logic [5:0] h, bit sort);
      int s;
      s = int'(mdl_node_slot[h]);
      if (s == 0) return ST_ABSENT;
      if (s < mdl_count) put(mdl_slot_node[mdl_count], s);
      mdl_node_slot[h] = 0;
      mdl_count--;
      if (sort && s <= mdl_count && !bubble_up(s)) bubble_down(s);
      return ST_OK;
   endfunction

   function automatic heap_view_type heap_apply(heap_op_type c);
      heap_view_type v;
      logic [1:0] st;
      st = ST_OK;
      case (c.op)
         OP_INSERT:     st = heap_add(c.node, c.prio, 1);
         OP_REMOVE:     st = heap_drop(c.node, 1);
         OP_CHANGE:
            if (mdl_node_slot[c.node] == 0) st = ST_ABSENT;
            else begin
               mdl_node_prio[c.node] = c.prio;
               if (!bubble_up(int'(mdl_node_slot[c.node])))
                  bubble_down(int'(mdl_node_slot[c.node]));
            end
         OP_RAW_INSERT: st = heap_add(c.node, c.prio, 0);
         OP_RAW_REMOVE: st = heap_drop(c.node, 0);
         OP_REBUILD:
            for (int i = mdl_count / 2; i >= 1; i--) bubble_down(i);
         default: ;
      endcase
      v.top_valid = mdl_count > 0;
      v.top_node  = v.top_valid ? mdl_slot_node[1] : '0;
      v.top_prio  = v.top_valid ? prio_of(1) : '0;
      v.count     = mdl_count[6:0];
      v.status    = st;
      return v;
   endfunction

   // ---- request side ----
   // valid stays up after an accepted word until the next word or an idle gap
   task automatic send_word(heap_op_type c);
      while ($urandom_range(99) < 22 && !(words_out > 300 && words_out < 450)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS - 73){1'b0}}, c.prio, c.node, c.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      op_seen[c.op]++;
   endtask

   function automatic heap_op_type rand_op();
      heap_op_type c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)      c.op = OP_INSERT;
      else if (pick < 62) c.op = OP_REMOVE;
      else if (pick < 80) c.op = OP_CHANGE;
      else if (pick < 87) c.op = OP_RAW_INSERT;
      else if (pick < 93) c.op = OP_RAW_REMOVE;
      else if (pick < 98) c.op = OP_REBUILD;
      else                c.op = 3'($urandom_range(7, 6));
      c.node = 6'($urandom_range(63));
      // narrow priorities give plenty of ties
      case ($urandom_range(3))
         0:       c.prio = 64'($urandom_range(7));
         1:       c.prio = {$urandom, $urandom};
         2:       c.prio = {1'($urandom_range(1)), 61'd0, 2'($urandom_range(3))};
         default: c.prio = 64'($urandom_range(1000));
      endcase
      return c;
   endfunction

   stim_row_type directed [$];

   function automatic void add_row(logic [2:0] op, logic [5:0] node, logic [63:0] prio,
                                   bit known = 0, heap_view_type v = '0);
      stim_row_type r;
      r.cmd = '{op, node, prio};
      r.has_view = known;
      r.view = v;
      directed.push_back(r);
   endfunction

   initial begin
      heap_view_type v;
      heap_op_type   c;
      mdl_count = 0;
      foreach (mdl_node_slot[i]) mdl_node_slot[i] = '0;
      foreach (mdl_node_prio[i]) mdl_node_prio[i] = '0;
      foreach (mdl_slot_node[i]) mdl_slot_node[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (st_seen[i]) st_seen[i] = 0;

      // directed table: empty heap cases, extremes, ties, every operation
      add_row(OP_REMOVE, 6'd5, '0, 1, '{1'b0, 6'd0, 64'd0, 7'd0, ST_ABSENT});
      add_row(OP_CHANGE, 6'd63, '1, 1, '{1'b0, 6'd0, 64'd0, 7'd0, ST_ABSENT});
      add_row(OP_REBUILD, 6'd0, '0, 1, '{1'b0, 6'd0, 64'd0, 7'd0, ST_OK});
      add_row(OP_INSERT, 6'd0, '0, 1, '{1'b1, 6'd0, 64'd0, 7'd1, ST_OK});
      add_row(OP_INSERT, 6'd0, 64'd9, 1, '{1'b1, 6'd0, 64'd0, 7'd1, ST_PRESENT});
      add_row(OP_INSERT, 6'd63, '1, 1, '{1'b1, 6'd63, '1, 7'd2, ST_OK});
      add_row(OP_INSERT, 6'd21, 64'h5555_5555_5555_5555);
      add_row(OP_INSERT, 6'd42, 64'hAAAA_AAAA_AAAA_AAAA);
      add_row(OP_INSERT, 6'd7, '1);
      add_row(3'd6, 6'd1, 64'd1);
      add_row(3'd7, 6'd2, 64'd2);
      add_row(OP_REMOVE, 6'd63, '0);
      add_row(OP_CHANGE, 6'd0, 64'h8000_0000_0000_0000);
      add_row(OP_CHANGE, 6'd0, 64'd1);
      add_row(OP_RAW_INSERT, 6'd50, '1);
      add_row(OP_RAW_INSERT, 6'd51, 64'd3);
      add_row(OP_REBUILD, 6'd9, 64'd9);
      add_row(OP_RAW_REMOVE, 6'd50, '0);
      add_row(OP_RAW_REMOVE, 6'd50, '0, 1, '{1'b1, 6'd7, '1, 7'd5, ST_ABSENT});
      add_row(OP_REMOVE, 6'd7, '0);
      add_row(OP_REBUILD, 6'd0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         v = heap_apply(directed[i].cmd);
         if (directed[i].has_view && v != directed[i].view) begin
            $display("%0t predictor row %0d: expected %p actual %p",
                     $time, i, directed[i].view, v);
            errors++;
         end
         expected_views.push_back(v);
         send_word(directed[i].cmd);
      end

      // fill to capacity (every handle present), then random traffic
      for (int h = 0; h < HANDLE_COUNT; h++) begin
         c = '{OP_INSERT, 6'(h), {$urandom, $urandom}};
         expected_views.push_back(heap_apply(c));
         send_word(c);
      end
      c = '{OP_INSERT, 6'd3, 64'd1};
      expected_views.push_back(heap_apply(c));
      send_word(c);
      for (int n = 0; n < N_RANDOM; n++) begin
         c = rand_op();
         // keep the heap from sitting full for long
         if (mdl_count > 56 && c.op == OP_INSERT && $urandom_range(1)) c.op = OP_REMOVE;
         expected_views.push_back(heap_apply(c));
         send_word(c);
      end
      req_tvalid <= 1'b0;
      stim_done  <= 1'b1;
   end

   // ---- response side ----
   initial begin
      @(negedge reset);
      // long hold-off while requests keep coming
      repeat (40) @(posedge clock);
      hold_off <= 1'b1;
      for (int i = 0; i < 300; i++) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off) rsp_tready <= 1'b0;
      else if (words_out > 300 && words_out < 450) rsp_tready <= 1'b1;
      else rsp_tready <= $urandom_range(99) >= 22;
   end

   always @(posedge clock) begin
      heap_view_type got;
      heap_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.top_valid = rsp_tdata[0];
         got.top_node  = rsp_tdata[1 +: 6];
         got.top_prio  = rsp_tdata[PRIO_LSB +: 64];
         got.count     = rsp_tdata[CNT_LSB +: 7];
         got.status    = rsp_tdata[ST_LSB +: 2];
         words_out <= words_out + 1;
         if (expected_views.size() == 0) begin
            $display("%0t unexpected response word: actual %p", $time, got);
            errors++;
         end else begin
            want = expected_views.pop_front();
            st_seen[want.status]++;
            if (got.top_valid !== want.top_valid || got.top_node !== want.top_node ||
                got.top_prio !== want.top_prio || got.count !== want.count ||
                got.status !== want.status) begin
               $display("%0t response mismatch: expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // ---- watchdog and end of run ----
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired with %0d responses outstanding", expected_views.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      wait (stim_done && expected_views.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d responses; ops ins %0d rem %0d chg %0d raw %0d/%0d rebuild %0d",
               words_out, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
               op_seen[5]);
      $display("statuses ok %0d full %0d present %0d absent %0d",
               st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
      if (errors == 0 && expected_views.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
